FILE: rtl/core/fgdr_pkg.sv
`timescale 1ns / 1ps
// Shared types, constants and the 5x7 font table of the glyph dot rasterizer.
// Used by every module in rtl/core; depends on nothing.
package fgdr_pkg;

  localparam int unsigned SCREEN_WIDTH_DEF  = 128;
  localparam int unsigned SCREEN_HEIGHT_DEF = 160;

  localparam logic [7:0] GLYPH_FIRST = 8'd32;
  localparam logic [7:0] GLYPH_LAST  = 8'd127;
  localparam int unsigned GLYPH_COUNT = 96;
  localparam int unsigned GLYPH_COLS  = 5;
  localparam int unsigned GLYPH_ROWS  = 8;
  localparam int unsigned GLYPH_BITS  = GLYPH_COLS * GLYPH_ROWS;

  localparam logic [2:0] COL_LAST = 3'(GLYPH_COLS - 1);
  localparam logic [2:0] ROW_LAST = 3'(GLYPH_ROWS - 1);

  // Scanner to geometry: one font dot cell per transfer.
  typedef struct packed {
    logic        valid;
    logic        lit;
    logic        done;   // last cell of the glyph
    logic [2:0]  col;
    logic [2:0]  row;
    logic [8:0]  ox;
    logic [8:0]  oy;
    logic [4:0]  scale;
    logic [15:0] color;
  } dot_t;

  // Geometry to marker: one rectangle candidate per transfer.
  typedef struct packed {
    logic        valid;
    logic        emit;   // lit and fully on screen
    logic        done;
    logic [6:0]  x0;
    logic [7:0]  y0;
    logic [6:0]  x1;
    logic [7:0]  y1;
    logic [15:0] color;
  } rect_tok_t;

  // Each entry holds the five column bytes, column 0 in the low byte;
  // bit r of a column byte is row r.
  localparam logic [GLYPH_BITS-1:0] FONT_ROM [GLYPH_COUNT] = '{
    40'h0000000000, 40'h00005f0000, 40'h0007000700, 40'h147f147f14,
    40'h122a7f2a24, 40'h6264081323, 40'h5022554936, 40'h0000030500,
    40'h0041221c00, 40'h001c224100, 40'h082a1c2a08, 40'h08083e0808,
    40'h0000305000, 40'h0808080808, 40'h0000606000, 40'h0204081020,
    40'h3e4549513e, 40'h00407f4200, 40'h4649516142, 40'h314b454121,
    40'h107f121418, 40'h3945454527, 40'h3049494a3c, 40'h0305097101,
    40'h3649494936, 40'h1e29494906, 40'h0000363600, 40'h0000365600,
    40'h0041221408, 40'h1414141414, 40'h0814224100, 40'h0609510102,
    40'h3e41794932, 40'h7e1111117e, 40'h364949497f, 40'h224141413e,
    40'h1c2241417f, 40'h414949497f, 40'h010909097f, 40'h7a4949413e,
    40'h7f0808087f, 40'h00417f4100, 40'h013f414020, 40'h412214087f,
    40'h404040407f, 40'h7f020c027f, 40'h7f1008047f, 40'h3e4141413e,
    40'h060909097f, 40'h5e2151413e, 40'h462919097f, 40'h3149494946,
    40'h01017f0101, 40'h3f4040403f, 40'h1f2040201f, 40'h3f4038403f,
    40'h6314081463, 40'h0708700807, 40'h4345495161, 40'h0041417f00,
    40'h2010080402, 40'h007f414100, 40'h0402010204, 40'h4040404040,
    40'h0004020100, 40'h7854545420, 40'h384444487f, 40'h2044444438,
    40'h7f48444438, 40'h1854545438, 40'h0201097e08, 40'h3e5252520c,
    40'h780404087f, 40'h00407d4400, 40'h003d444020, 40'h004428107f,
    40'h00407f4100, 40'h780418047c, 40'h780404087c, 40'h3844444438,
    40'h081414147c, 40'h7c18141408, 40'h080404087c, 40'h2054545448,
    40'h2040443f04, 40'h7c2040403c, 40'h1c2040201c, 40'h3c4030403c,
    40'h4428102844, 40'h3c5050500c, 40'h444c546444, 40'h0041413608,
    40'h0000770000, 40'h0836414100, 40'h081c2a0808, 40'h0000000000
  };

endpackage

FILE: rtl/core/fgdr_scan.sv
`timescale 1ns / 1ps
// Request register and glyph cell scanner: walks the 40 font cells of one glyph.
// Depends on fgdr_pkg for the font table and the dot_t token.
module fgdr_scan (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           req_valid_i,
  output logic           req_ready_o,
  input  logic [8:0]     origin_x_i,
  input  logic [8:0]     origin_y_i,
  input  logic [7:0]     char_code_i,
  input  logic [15:0]    dot_color_i,
  input  logic [4:0]     scale_i,
  input  logic           adv_i,
  output fgdr_pkg::dot_t dot_o
);
  import fgdr_pkg::*;

  logic                  busy_q, busy_d;
  logic [2:0]            col_q, col_d;
  logic [2:0]            row_q, row_d;
  logic [GLYPH_BITS-1:0] glyph_q, glyph_d;
  logic [8:0]            ox_q, oy_q;
  logic [15:0]           color_q;
  logic [4:0]            scale_q;
  logic                  last_cell;
  logic                  accept;
  logic                  code_ok;
  logic [6:0]            rom_idx;

  assign last_cell   = (col_q == COL_LAST) && (row_q == ROW_LAST);
  assign req_ready_o = !busy_q || (last_cell && adv_i);
  assign accept      = req_valid_i && req_ready_o;
  assign code_ok     = (char_code_i >= GLYPH_FIRST) && (char_code_i <= GLYPH_LAST) &&
                       (scale_i != 5'd0);
  assign rom_idx     = 7'(char_code_i - GLYPH_FIRST);

  always_comb begin
    busy_d  = busy_q;
    col_d   = col_q;
    row_d   = row_q;
    glyph_d = glyph_q;
    if (accept) begin
      // A request with a code outside the font or a zero scale never occupies the scanner.
      busy_d  = code_ok;
      col_d   = 3'd0;
      row_d   = 3'd0;
      glyph_d = code_ok ? FONT_ROM[rom_idx] : '0;
    end else if (busy_q && adv_i) begin
      if (last_cell) begin
        busy_d = 1'b0;
      end else begin
        glyph_d = glyph_q >> 1;
        if (row_q == ROW_LAST) begin
          row_d = 3'd0;
          col_d = col_q + 3'd1;
        end else begin
          row_d = row_q + 3'd1;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
    end else begin
      busy_q <= busy_d;
    end
  end

  always_ff @(posedge clk_i) begin
    col_q   <= col_d;
    row_q   <= row_d;
    glyph_q <= glyph_d;
    if (accept) begin
      ox_q    <= origin_x_i;
      oy_q    <= origin_y_i;
      color_q <= dot_color_i;
      scale_q <= scale_i;
    end
  end

  always_comb begin
    dot_o.valid = busy_q;
    dot_o.lit   = glyph_q[0];
    dot_o.done  = last_cell;
    dot_o.col   = col_q;
    dot_o.row   = row_q;
    dot_o.ox    = ox_q;
    dot_o.oy    = oy_q;
    dot_o.scale = scale_q;
    dot_o.color = color_q;
  end

endmodule

FILE: rtl/core/fgdr_geom.sv
`timescale 1ns / 1ps
// Three-stage rectangle pipeline: cell offsets, screen corners, on-screen test.
// Depends on fgdr_pkg for the dot_t and rect_tok_t tokens.
module fgdr_geom #(
  parameter int unsigned ScreenWidth  = fgdr_pkg::SCREEN_WIDTH_DEF,
  parameter int unsigned ScreenHeight = fgdr_pkg::SCREEN_HEIGHT_DEF
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  fgdr_pkg::dot_t      dot_i,
  output logic                adv_o,
  output fgdr_pkg::rect_tok_t tok_o,
  input  logic                tok_ready_i
);
  import fgdr_pkg::*;

  localparam logic signed [10:0] WidthLim  = 11'(ScreenWidth);
  localparam logic signed [10:0] HeightLim = 11'(ScreenHeight);

  // Stage 1: offsets of the cell's near and far edges.
  logic        s1_valid_q, s1_lit_q, s1_done_q;
  logic [7:0]  s1_cx_q, s1_cxe_q, s1_cy_q, s1_cye_q;
  logic [8:0]  s1_ox_q, s1_oy_q;
  logic [15:0] s1_color_q;
  logic [7:0]  cx_d, cy_d;

  // Stage 2: corners in screen coordinates.
  logic               s2_valid_q, s2_lit_q, s2_done_q;
  logic signed [10:0] s2_x0_q, s2_xe_q, s2_y0_q, s2_ye_q;
  logic [15:0]        s2_color_q;

  // Stage 3: visibility and final rectangle.
  logic        s3_valid_q, s3_emit_q, s3_done_q;
  logic [6:0]  s3_x0_q, s3_x1_q;
  logic [7:0]  s3_y0_q, s3_y1_q;
  logic [15:0] s3_color_q;
  logic        fits;
  logic signed [10:0] xl, yl;

  assign adv_o = !s3_valid_q || tok_ready_i;

  assign cx_d = 8'(dot_i.col) * 8'(dot_i.scale);
  assign cy_d = 8'(dot_i.row) * 8'(dot_i.scale);

  assign fits = (s2_x0_q >= 0) && (s2_xe_q <= WidthLim) &&
                (s2_y0_q >= 0) && (s2_ye_q <= HeightLim);
  assign xl   = s2_xe_q - 11'sd1;
  assign yl   = s2_ye_q - 11'sd1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      s2_valid_q <= 1'b0;
      s3_valid_q <= 1'b0;
    end else if (adv_o) begin
      s1_valid_q <= dot_i.valid;
      s2_valid_q <= s1_valid_q;
      s3_valid_q <= s2_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_o) begin
      s1_lit_q   <= dot_i.lit;
      s1_done_q  <= dot_i.done;
      s1_cx_q    <= cx_d;
      s1_cxe_q   <= cx_d + 8'(dot_i.scale);
      s1_cy_q    <= cy_d;
      s1_cye_q   <= cy_d + 8'(dot_i.scale);
      s1_ox_q    <= dot_i.ox;
      s1_oy_q    <= dot_i.oy;
      s1_color_q <= dot_i.color;

      s2_lit_q   <= s1_lit_q;
      s2_done_q  <= s1_done_q;
      s2_x0_q    <= $signed({{2{s1_ox_q[8]}}, s1_ox_q}) + $signed({3'b000, s1_cx_q});
      s2_xe_q    <= $signed({{2{s1_ox_q[8]}}, s1_ox_q}) + $signed({3'b000, s1_cxe_q});
      s2_y0_q    <= $signed({{2{s1_oy_q[8]}}, s1_oy_q}) + $signed({3'b000, s1_cy_q});
      s2_ye_q    <= $signed({{2{s1_oy_q[8]}}, s1_oy_q}) + $signed({3'b000, s1_cye_q});
      s2_color_q <= s1_color_q;

      s3_emit_q  <= s2_lit_q && fits;
      s3_done_q  <= s2_done_q;
      s3_x0_q    <= s2_x0_q[6:0];
      s3_x1_q    <= xl[6:0];
      s3_y0_q    <= s2_y0_q[7:0];
      s3_y1_q    <= yl[7:0];
      s3_color_q <= s2_color_q;
    end
  end

  always_comb begin
    tok_o.valid = s3_valid_q;
    tok_o.emit  = s3_emit_q;
    tok_o.done  = s3_done_q;
    tok_o.x0    = s3_x0_q;
    tok_o.y0    = s3_y0_q;
    tok_o.x1    = s3_x1_q;
    tok_o.y1    = s3_y1_q;
    tok_o.color = s3_color_q;
  end

endmodule

FILE: rtl/core/fgdr_mark.sv
`timescale 1ns / 1ps
// Holds back each rectangle until the next one or the glyph end shows whether it is
// the last; drives the output register. Depends on fgdr_pkg for rect_tok_t.
module fgdr_mark (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  fgdr_pkg::rect_tok_t tok_i,
  output logic                tok_ready_o,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output logic [6:0]          rect_x0_o,
  output logic [7:0]          rect_y0_o,
  output logic [6:0]          rect_x1_o,
  output logic [7:0]          rect_y1_o,
  output logic [15:0]         rect_color_o,
  output logic                last_dot_o
);
  import fgdr_pkg::*;

  logic        hold_valid_q, hold_closed_q;
  logic [6:0]  hold_x0_q, hold_x1_q;
  logic [7:0]  hold_y0_q, hold_y1_q;
  logic [15:0] hold_color_q;

  logic        out_valid_q;
  logic [6:0]  out_x0_q, out_x1_q;
  logic [7:0]  out_y0_q, out_y1_q;
  logic [15:0] out_color_q;
  logic        out_last_q;

  logic out_free, tok_take, tok_emit, hold_move;

  assign out_free    = !out_valid_q || out_ready_i;
  assign tok_emit    = tok_i.valid && tok_i.emit;
  assign tok_ready_o = !tok_i.emit || !hold_valid_q || out_free;
  assign tok_take    = tok_i.valid && tok_ready_o;
  // The held rectangle leaves once its last flag is known and the output has room.
  assign hold_move   = hold_valid_q && out_free && (hold_closed_q || tok_emit);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hold_valid_q  <= 1'b0;
      hold_closed_q <= 1'b0;
      out_valid_q   <= 1'b0;
    end else begin
      if (tok_take && tok_i.emit) begin
        hold_valid_q  <= 1'b1;
        hold_closed_q <= tok_i.done;
      end else if (hold_move) begin
        hold_valid_q <= 1'b0;
      end else if (tok_take && tok_i.done && hold_valid_q) begin
        hold_closed_q <= 1'b1;
      end
      if (hold_move) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (tok_take && tok_i.emit) begin
      hold_x0_q    <= tok_i.x0;
      hold_y0_q    <= tok_i.y0;
      hold_x1_q    <= tok_i.x1;
      hold_y1_q    <= tok_i.y1;
      hold_color_q <= tok_i.color;
    end
    if (hold_move) begin
      out_x0_q    <= hold_x0_q;
      out_y0_q    <= hold_y0_q;
      out_x1_q    <= hold_x1_q;
      out_y1_q    <= hold_y1_q;
      out_color_q <= hold_color_q;
      out_last_q  <= hold_closed_q;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign rect_x0_o    = out_x0_q;
  assign rect_y0_o    = out_y0_q;
  assign rect_x1_o    = out_x1_q;
  assign rect_y1_o    = out_y1_q;
  assign rect_color_o = out_color_q;
  assign last_dot_o   = out_last_q;

endmodule

FILE: rtl/core/font_glyph_dot_rasterizer.sv
`timescale 1ns / 1ps
// Top level of the 5x7 font glyph dot rasterizer; instantiates fgdr_scan, fgdr_geom, fgdr_mark.
// Path: the scanner registers the request; each cell passes the three geometry stages, and each
// rectangle waits in the marker's hold register for the next drawn cell or the final cell.
// Throughput: the scanner visits the 40 font cells of a glyph one per cycle when not stalled;
// a code outside 32..127 or a zero scale is taken without occupying it, with no output.
// Reset (rst_ni low, asynchronous) clears all valid bits; no request or rectangle survives it.
module font_glyph_dot_rasterizer #(
  parameter int unsigned ScreenWidth  = fgdr_pkg::SCREEN_WIDTH_DEF,
  parameter int unsigned ScreenHeight = fgdr_pkg::SCREEN_HEIGHT_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // Request stream.
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // [8:0] origin_x, [17:9] origin_y, [25:18] char_code, [41:26] dot_color,
  // [46:42] scale, [47] zero
  input  logic [47:0] s_axis_tdata,
  // Rectangle stream.
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // [6:0] rect_x0, [14:7] rect_y0, [21:15] rect_x1, [29:22] rect_y1,
  // [45:30] rect_color, [47:46] zero
  output logic [47:0] m_axis_tdata,
  // last_dot: marks the final rectangle of a character
  output logic        m_axis_tlast
);
  import fgdr_pkg::*;

  // The design is a short pipeline. The scanner holds one request and steps through
  // the glyph column by column, row by row, issuing one cell per cycle when not stalled, lit or
  // not, with a flag on the final cell. The geometry stages turn each cell into a
  // rectangle and decide whether it is lit and fully on screen. The marker keeps the
  // newest emitted rectangle back until the next emitted one or the final-cell flag
  // arrives, which tells it whether that rectangle closes the character.
  // Every stage advances together when the stage ahead of it can take a transfer,
  // so back-pressure on the rectangle stream stalls the scan without losing cells.
  // The next request is taken in the cycle the scanner issues the final cell.

  dot_t      dot;
  rect_tok_t tok;
  logic      adv;
  logic      tok_ready;

  logic [6:0]  rect_x0, rect_x1;
  logic [7:0]  rect_y0, rect_y1;
  logic [15:0] rect_color;

  fgdr_scan u_scan (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_valid_i (s_axis_tvalid),
    .req_ready_o (s_axis_tready),
    .origin_x_i  (s_axis_tdata[8:0]),
    .origin_y_i  (s_axis_tdata[17:9]),
    .char_code_i (s_axis_tdata[25:18]),
    .dot_color_i (s_axis_tdata[41:26]),
    .scale_i     (s_axis_tdata[46:42]),
    .adv_i       (adv),
    .dot_o       (dot)
  );

  fgdr_geom #(
    .ScreenWidth  (ScreenWidth),
    .ScreenHeight (ScreenHeight)
  ) u_geom (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .dot_i       (dot),
    .adv_o       (adv),
    .tok_o       (tok),
    .tok_ready_i (tok_ready)
  );

  fgdr_mark u_mark (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .tok_i        (tok),
    .tok_ready_o  (tok_ready),
    .out_valid_o  (m_axis_tvalid),
    .out_ready_i  (m_axis_tready),
    .rect_x0_o    (rect_x0),
    .rect_y0_o    (rect_y0),
    .rect_x1_o    (rect_x1),
    .rect_y1_o    (rect_y1),
    .rect_color_o (rect_color),
    .last_dot_o   (m_axis_tlast)
  );

  assign m_axis_tdata = {2'b00, rect_color, rect_y1, rect_x1, rect_y0, rect_x0};

endmodule

FILE: rtl/core/fgdr_checker.sv
`timescale 1ns / 1ps
// Port-level checks of the glyph dot rasterizer and the bind that attaches them.
// Depends on fgdr_pkg for the default screen size.
module fgdr_checker #(
  parameter int unsigned ScreenWidth  = fgdr_pkg::SCREEN_WIDTH_DEF,
  parameter int unsigned ScreenHeight = fgdr_pkg::SCREEN_HEIGHT_DEF
) (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [47:0] m_axis_tdata,
  input logic        m_axis_tlast
);
  import fgdr_pkg::*;

  logic [7:0] x0, x1, y0, y1;

  assign x0 = {1'b0, m_axis_tdata[6:0]};
  assign y0 = m_axis_tdata[14:7];
  assign x1 = {1'b0, m_axis_tdata[21:15]};
  assign y1 = m_axis_tdata[29:22];

  // A rectangle waiting on the sink keeps its contents.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast))
    else $error("stalled rectangle changed");

  // Every rectangle is a square font dot.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (x1 >= x0) && (y1 >= y0) && ((x1 - x0) == (y1 - y0)))
    else $error("rectangle is not a square");

  // Rectangles stay on screen.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (32'(y1) < ScreenHeight) && (32'(x1) < ScreenWidth))
    else $error("rectangle outside the screen");

  // Nothing is offered in the first cycle out of reset.
  assert property (@(posedge clk_i) $rose(rst_ni) |-> !m_axis_tvalid)
    else $error("output valid right after reset");

endmodule

bind font_glyph_dot_rasterizer fgdr_checker #(
  .ScreenWidth  (ScreenWidth),
  .ScreenHeight (ScreenHeight)
) u_fgdr_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tlast  (m_axis_tlast)
);

FILE: tb/tb_top.sv
`timescale 1ns / 1ps
// Self-checking testbench of font_glyph_dot_rasterizer: drives character requests and compares
// every rectangle with a predictor that holds its own copy of the 5x7 font.
// Depends on rtl/core/fgdr_pkg.sv and rtl/core/font_glyph_dot_rasterizer.sv.
module tb_top;
  import fgdr_pkg::GLYPH_FIRST;
  import fgdr_pkg::GLYPH_LAST;

  localparam int CLK_HALF_NS  = 4;
  localparam int RESET_CYCLES = 11;
  localparam int SCREEN_W     = 128;
  localparam int SCREEN_H     = 160;
  localparam int RANDOM_COUNT = 300;

  // The slowest correct run is about 330 requests, each with at most 40 rectangles that the
  // receiver may accept only at its slowest stall pattern, plus sender gaps and the glyph scans.
  // The limit leaves a wide margin on top of that.
  localparam int CYCLE_LIMIT = 500000;

  // A request whose dots all fall off screen still occupies the scanner while it walks its 40 cells,
  // and its final cell still passes the geometry stages and the marker; this covers anything in flight.
  localparam int SETTLE_CYCLES = 64;

  // Receiver stall patterns.
  localparam int READY_ALWAYS      = 0;
  localparam int READY_RANDOM      = 1;
  localparam int READY_EVERY_THIRD = 2;

  // Character codes used by the directed tests.
  localparam logic [7:0] CH_NUL   = 8'd0;
  localparam logic [7:0] CH_US    = 8'd31;
  localparam logic [7:0] CH_SPACE = 8'd32;
  localparam logic [7:0] CH_HASH  = 8'd35;
  localparam logic [7:0] CH_EIGHT = 8'd56;
  localparam logic [7:0] CH_AT    = 8'd64;
  localparam logic [7:0] CH_A     = 8'd65;
  localparam logic [7:0] CH_H     = 8'd72;
  localparam logic [7:0] CH_M     = 8'd77;
  localparam logic [7:0] CH_W     = 8'd87;
  localparam logic [7:0] CH_BAR   = 8'd124;
  localparam logic [7:0] CH_TILDE = 8'd126;
  localparam logic [7:0] CH_DEL   = 8'd127;
  localparam logic [7:0] CH_HIGH  = 8'd128;
  localparam logic [7:0] CH_MAX   = 8'd255;

  // Font for codes 32..127. Each entry lists the five column bytes with column 0 in the
  // most significant byte; bit r of a column byte lights row r.
  localparam logic [39:0] GLYPH_COLUMNS [96] = '{
    40'h0000000000, 40'h00005f0000, 40'h0007000700, 40'h147f147f14,
    40'h242a7f2a12, 40'h2313086462, 40'h3649552250, 40'h0005030000,
    40'h001c224100, 40'h0041221c00, 40'h082a1c2a08, 40'h08083e0808,
    40'h0050300000, 40'h0808080808, 40'h0060600000, 40'h2010080402,
    40'h3e5149453e, 40'h00427f4000, 40'h4261514946, 40'h2141454b31,
    40'h1814127f10, 40'h2745454539, 40'h3c4a494930, 40'h0171090503,
    40'h3649494936, 40'h064949291e, 40'h0036360000, 40'h0056360000,
    40'h0814224100, 40'h1414141414, 40'h0041221408, 40'h0201510906,
    40'h324979413e, 40'h7e1111117e, 40'h7f49494936, 40'h3e41414122,
    40'h7f4141221c, 40'h7f49494941, 40'h7f09090901, 40'h3e4149497a,
    40'h7f0808087f, 40'h00417f4100, 40'h2040413f01, 40'h7f08142241,
    40'h7f40404040, 40'h7f020c027f, 40'h7f0408107f, 40'h3e4141413e,
    40'h7f09090906, 40'h3e4151215e, 40'h7f09192946, 40'h4649494931,
    40'h01017f0101, 40'h3f4040403f, 40'h1f2040201f, 40'h3f4038403f,
    40'h6314081463, 40'h0708700807, 40'h6151494543, 40'h007f414100,
    40'h0204081020, 40'h0041417f00, 40'h0402010204, 40'h4040404040,
    40'h0001020400, 40'h2054545478, 40'h7f48444438, 40'h3844444420,
    40'h384444487f, 40'h3854545418, 40'h087e090102, 40'h0c5252523e,
    40'h7f08040478, 40'h00447d4000, 40'h2040443d00, 40'h7f10284400,
    40'h00417f4000, 40'h7c04180478, 40'h7c08040478, 40'h3844444438,
    40'h7c14141408, 40'h081414187c, 40'h7c08040408, 40'h4854545420,
    40'h043f444020, 40'h3c4040207c, 40'h1c2040201c, 40'h3c4030403c,
    40'h4428102844, 40'h0c5050503c, 40'h4464544c44, 40'h0836414100,
    40'h0000770000, 40'h0041413608, 40'h08082a1c08, 40'h0000000000
  };

  typedef struct {
    logic [6:0]  x0;
    logic [7:0]  y0;
    logic [6:0]  x1;
    logic [7:0]  y1;
    logic [15:0] color;
    logic        last;
  } rect_t;

  logic        clk_i = 1'b0;
  logic        rst_ni;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  // [8:0] origin_x, [17:9] origin_y, [25:18] char_code, [41:26] dot_color,
  // [46:42] scale, [47] zero
  logic [47:0] s_axis_tdata;
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  // [6:0] rect_x0, [14:7] rect_y0, [21:15] rect_x1, [29:22] rect_y1,
  // [45:30] rect_color, [47:46] zero
  logic [47:0] m_axis_tdata;
  logic        m_axis_tlast;

  rect_t expected_rects[$];
  int    error_count = 0;
  int    cycle_count = 0;
  int    burst_left  = 0;
  int    hold_cycles = 0;

  font_glyph_dot_rasterizer uut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tlast (m_axis_tlast)
  );

  always #CLK_HALF_NS clk_i = ~clk_i;

  // Watchdog: a hung handshake or a lost rectangle ends the run here.
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("FAILED: results differ");
      $finish;
    end
  end

  task automatic report_mismatch(input string msg);
    $display("ERROR @%0t: %s", $realtime, msg);
    error_count++;
  endtask

  // Predicts the rectangles of one request. Dots are visited column by column and, within a
  // column, from the top row down; a dot is kept only when its whole square is on screen.
  // The most recent kept rectangle is held back so that the final one can carry the mark.
  function automatic void render_glyph(input logic [8:0] ox_bits, input logic [8:0] oy_bits,
                                       input logic [7:0] code, input logic [15:0] color,
                                       input logic [4:0] scale);
    int          ox;
    int          oy;
    int          s;
    int          x0;
    int          y0;
    logic [39:0] glyph;
    logic [7:0]  column;
    rect_t       held;
    bit          have_held;
    ox = $signed(ox_bits);
    oy = $signed(oy_bits);
    s = scale;
    have_held = 1'b0;
    if (code < GLYPH_FIRST || code > GLYPH_LAST || s == 0) return;
    glyph = GLYPH_COLUMNS[code - GLYPH_FIRST];
    for (int col = 0; col < 5; col++) begin
      column = glyph[39 - 8 * col -: 8];
      for (int row = 0; row < 8; row++) begin
        x0 = ox + col * s;
        y0 = oy + row * s;
        if (column[row] && x0 >= 0 && x0 + s <= SCREEN_W && y0 >= 0 && y0 + s <= SCREEN_H) begin
          if (have_held) expected_rects.push_back(held);
          held.x0    = 7'(x0);
          held.y0    = 8'(y0);
          held.x1    = 7'(x0 + s - 1);
          held.y1    = 8'(y0 + s - 1);
          held.color = color;
          held.last  = 1'b0;
          have_held  = 1'b1;
        end
      end
    end
    if (have_held) begin
      held.last = 1'b1;
      expected_rects.push_back(held);
    end
  endfunction

  // Offers one request. The sender runs in bursts and may idle at the start of each burst.
  // The prediction is made at the edge where the transfer happens.
  task automatic send_request(input logic [8:0] ox, input logic [8:0] oy,
                              input logic [7:0] code, input logic [15:0] color,
                              input logic [4:0] scale);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 16);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      repeat (gap) begin
        @(negedge clk_i);
        s_axis_tvalid <= 1'b0;
      end
    end
    burst_left--;
    @(negedge clk_i);
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {1'b0, scale, color, code, oy, ox};
    do @(posedge clk_i); while (!s_axis_tready);
    render_glyph(ox, oy, code, color, scale);
  endtask

  // Receiver: switches between stall patterns in segments of random length. A hold request
  // from a test overrides the pattern and keeps tready low until the hold count runs out.
  initial begin : receiver
    int seg_left;
    int mode;
    int phase;
    m_axis_tready = 1'b0;
    seg_left = 0;
    mode = READY_ALWAYS;
    phase = 0;
    forever begin
      @(negedge clk_i);
      if (hold_cycles > 0) begin
        hold_cycles--;
        m_axis_tready <= 1'b0;
      end else begin
        if (seg_left == 0) begin
          seg_left = $urandom_range(20, 200);
          mode = $urandom_range(READY_ALWAYS, READY_EVERY_THIRD);
        end
        seg_left--;
        phase++;
        case (mode)
          READY_ALWAYS: begin
            m_axis_tready <= 1'b1;
          end
          READY_RANDOM: begin
            m_axis_tready <= ($urandom_range(0, 99) >= 30);
          end
          default: begin
            m_axis_tready <= (phase % 3 == 0);
          end
        endcase
      end
    end
  end

  // Every rectangle transfer is compared field by field with the oldest prediction.
  always @(posedge clk_i) begin : check_rects
    rect_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (expected_rects.size() == 0) begin
        report_mismatch($sformatf("rectangle %h with none expected", m_axis_tdata));
      end else begin
        want = expected_rects.pop_front();
        if (m_axis_tdata[6:0] !== want.x0)
          report_mismatch($sformatf("rect_x0 %0d, expected %0d", m_axis_tdata[6:0], want.x0));
        if (m_axis_tdata[14:7] !== want.y0)
          report_mismatch($sformatf("rect_y0 %0d, expected %0d", m_axis_tdata[14:7], want.y0));
        if (m_axis_tdata[21:15] !== want.x1)
          report_mismatch($sformatf("rect_x1 %0d, expected %0d", m_axis_tdata[21:15], want.x1));
        if (m_axis_tdata[29:22] !== want.y1)
          report_mismatch($sformatf("rect_y1 %0d, expected %0d", m_axis_tdata[29:22], want.y1));
        if (m_axis_tdata[45:30] !== want.color)
          report_mismatch($sformatf("rect_color %h, expected %h", m_axis_tdata[45:30],
                                    want.color));
        if (m_axis_tlast !== want.last)
          report_mismatch($sformatf("last_dot %b, expected %b", m_axis_tlast, want.last));
      end
    end
  end

  // Ordinary glyphs at small scales, the blank glyphs at both ends of the font and the
  // highest printable code.
  task automatic test_basic_glyphs();
    send_request(9'd0, 9'd0, CH_A, 16'hffff, 5'd1);
    send_request(9'd10, 9'd20, CH_AT, 16'h0000, 5'd2);
    send_request(9'd40, 9'd50, CH_TILDE, 16'ha5a5, 5'd3);
    send_request(9'd5, 9'd5, CH_SPACE, 16'h5a5a, 5'd1);
    send_request(9'd5, 9'd5, CH_DEL, 16'h1234, 5'd1);
  endtask

  // Codes outside the font and a zero scale must produce nothing at all.
  task automatic test_unrenderable();
    send_request(9'd0, 9'd0, CH_NUL, 16'hffff, 5'd1);
    send_request(9'd0, 9'd0, CH_US, 16'hffff, 5'd1);
    send_request(9'd0, 9'd0, CH_HIGH, 16'hffff, 5'd1);
    send_request(9'd0, 9'd0, CH_MAX, 16'hffff, 5'd1);
    send_request(9'd0, 9'd0, CH_A, 16'hffff, 5'd0);
  endtask

  // The largest nominal scale fits entirely; scales above it are taken as given, so the
  // dots of a large glyph that spill off the bottom or the right edge are dropped.
  task automatic test_scale_extremes();
    send_request(9'd0, 9'd0, CH_HASH, 16'h07e0, 5'd16);
    send_request(9'd0, 9'd0, CH_W, 16'hf800, 5'd17);
    send_request(9'd0, 9'd0, CH_BAR, 16'h001f, 5'd31);
    send_request(9'd0, 9'd0, CH_M, 16'hffff, 5'd31);
  endtask

  // Origins at the range limits, a glyph that just fits the corner and glyphs that cross each screen border.
  task automatic test_screen_edges();
    send_request(9'h100, 9'h100, CH_H, 16'hffff, 5'd1);
    send_request(9'h0ff, 9'h0ff, CH_H, 16'hffff, 5'd1);
    send_request(9'd123, 9'd153, CH_HASH, 16'hc3c3, 5'd1);
    send_request(9'd124, 9'd154, CH_HASH, 16'h3c3c, 5'd1);
    send_request(9'h1ff, 9'h1ff, CH_H, 16'h8001, 5'd2);
    send_request(9'h1fd, 9'd0, CH_EIGHT, 16'h7ffe, 5'd1);
  endtask

  // The receiver stops for a long stretch while requests keep coming, so the block's
  // internal buffering fills and it has to drop tready on the request side.
  task automatic test_backpressure();
    hold_cycles = 400;
    burst_left = 0;
    for (int i = 0; i < 12; i++)
      send_request(9'($urandom_range(0, 100)), 9'($urandom_range(0, 120)), CH_HASH,
                   16'($urandom), 5'd1);
  endtask

  // Mostly printable glyphs on screen at small scales, so most requests draw something;
  // the rest use any code, any origin and any scale the fields allow.
  task automatic test_random_requests();
    logic [8:0]  ox;
    logic [8:0]  oy;
    logic [7:0]  code;
    logic [4:0]  scale;
    int          pick;
    for (int i = 0; i < RANDOM_COUNT; i++) begin
      code = ($urandom_range(0, 99) < 80) ? 8'($urandom_range(32, 127)) : 8'($urandom);
      pick = $urandom_range(0, 99);
      if (pick < 70) scale = 5'($urandom_range(1, 3));
      else if (pick < 90) scale = 5'($urandom_range(4, 16));
      else scale = 5'($urandom);
      if ($urandom_range(0, 99) < 75) begin
        ox = 9'($urandom_range(0, SCREEN_W - 1));
        oy = 9'($urandom_range(0, SCREEN_H - 1));
      end else begin
        ox = 9'($urandom);
        oy = 9'($urandom);
      end
      send_request(ox, oy, code, 16'($urandom), scale);
    end
  endtask

  initial begin
    rst_ni = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata = '0;
    repeat (RESET_CYCLES) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    test_basic_glyphs();
    test_unrenderable();
    test_scale_extremes();
    test_screen_edges();
    test_backpressure();
    test_random_requests();

    @(negedge clk_i);
    s_axis_tvalid <= 1'b0;
    while (expected_rects.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);

    if (error_count == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule

FILE: font_glyph_dot_rasterizer.f
rtl/core/fgdr_pkg.sv
rtl/core/fgdr_scan.sv
rtl/core/fgdr_geom.sv
rtl/core/fgdr_mark.sv
rtl/core/font_glyph_dot_rasterizer.sv
rtl/core/fgdr_checker.sv
tb/tb_top.sv
